/* hdl/sde_pkg.sv */
`timescale 1ns / 1ps
package sde_pkg;

   localparam int FREQ_W  = 18;
   localparam int AMP_W   = 16;
   localparam int RATIO_W = 16;
   localparam int DISS_W  = 23;
   localparam int CSR_W   = 4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [CSR_W-1:0]  PIU_RESET  = 4'd8;
   localparam logic [31:0]       SLOPE_Q20  = 32'd21706;
   localparam logic [36:0]       OFFSET_Q24 = 37'd318096015;
   localparam logic [31:0]       DSTAR_Q20  = 32'd251658;
   localparam logic [31:0]       RATE1_Q16  = 32'd230031;
   localparam logic [31:0]       RATE2_Q16  = 32'd376832;
   localparam logic [30:0]       Q30_ONE    = 31'h4000_0000;
   localparam logic [3:0]        SER_TERMS  = 4'd13;
   localparam logic [DISS_W-1:0] DISS_MAX   = 23'h7F_FFFF;

endpackage

/* hdl/sensory_dissonance_evaluator.sv */
`timescale 1ns / 1ps
// sensory dissonance evaluator
// req channel: operation 0 loads one partial (freq, amp) into table slot
// partial_index; slots at or above MAX_PARTIALS are ignored. operation 1
// evaluates the summed pair dissonance at interval_ratio over the first
// partials_in_use slots and gives one rsp item (dissonance, interval_out).
// a load gives no rsp item; loads can follow back to back.
// an evaluate runs on one shared multiplier and a bit-serial divider for x
// under a sequencer. it first works out e^-1 by the series, then for each
// row loads the row partial and runs that row's pairs (n*n pairs with n
// partials in use), and loads the rsp item in a final state. a pair's
// exponential takes longer as p, the whole part of its argument, grows;
// once p reaches 32 it is zero. n = 0 goes straight to the final state.
// req_stall is high from an evaluate until its result enters the rsp
// register; the next item is taken in the cycle after that, even while the
// result still waits there. rsp_stall holds the rsp register; a finished
// evaluate waits for it. csr write sets partials_in_use (reset 8); write
// only while idle. reset (synchronous) clears the partial table to zero,
// empties the rsp register and returns the sequencer to idle.
module sensory_dissonance_evaluator #(
   parameter int MAX_PARTIALS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [2:0]                    req_partial_index,
   input  logic [sde_pkg::FREQ_W-1:0]    req_partial_freq,
   input  logic [sde_pkg::AMP_W-1:0]     req_partial_amp,
   input  logic [sde_pkg::RATIO_W-1:0]   req_interval_ratio,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sde_pkg::DISS_W-1:0]    rsp_dissonance,
   output logic [sde_pkg::RATIO_W-1:0]   rsp_interval_out,
   input  logic                          csr_write_enable,
   input  logic [sde_pkg::CSR_W-1:0]     csr_write_data
);
   import sde_pkg::*;

   localparam int IDX_W = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
   localparam int CNT_W = $clog2(MAX_PARTIALS + 1);

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_SER_MUL   = 5'd1;
   localparam logic [4:0] ST_SER_RCP   = 5'd2;
   localparam logic [4:0] ST_DIV       = 5'd3;
   localparam logic [4:0] ST_SER_ACC   = 5'd4;
   localparam logic [4:0] ST_SER_END   = 5'd5;
   localparam logic [4:0] ST_POW       = 5'd6;
   localparam logic [4:0] ST_POW_UPD   = 5'd7;
   localparam logic [4:0] ST_EXP_START = 5'd8;
   localparam logic [4:0] ST_EXP_END   = 5'd9;
   localparam logic [4:0] ST_TERM_MUL  = 5'd10;
   localparam logic [4:0] ST_TERM_ADD  = 5'd11;
   localparam logic [4:0] ST_ROW_LD    = 5'd12;
   localparam logic [4:0] ST_COL_LD    = 5'd13;
   localparam logic [4:0] ST_SC_MUL    = 5'd14;
   localparam logic [4:0] ST_PREP      = 5'd15;
   localparam logic [4:0] ST_DEN_MUL   = 5'd16;
   localparam logic [4:0] ST_NUM_MUL   = 5'd17;
   localparam logic [4:0] ST_X_LD      = 5'd18;
   localparam logic [4:0] ST_X_DONE    = 5'd19;
   localparam logic [4:0] ST_A1_MUL    = 5'd20;
   localparam logic [4:0] ST_A2_MUL    = 5'd21;
   localparam logic [4:0] ST_A2_DONE   = 5'd22;
   localparam logic [4:0] ST_FIN       = 5'd23;

   logic [4:0]          state_ff, state_in;
   logic [CSR_W-1:0]    piu_ff, piu_in;
   logic [FREQ_W-1:0]   freq_tbl_ff [MAX_PARTIALS];
   logic [FREQ_W-1:0]   freq_tbl_in [MAX_PARTIALS];
   logic [AMP_W-1:0]    amp_tbl_ff [MAX_PARTIALS];
   logic [AMP_W-1:0]    amp_tbl_in [MAX_PARTIALS];
   logic [RATIO_W-1:0]  ratio_ff, ratio_in;
   logic [CNT_W-1:0]    n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [FREQ_W-1:0]   fi_ff, fi_in, fj_ff, fj_in;
   logic [AMP_W-1:0]    ai_ff, ai_in, aj_ff, aj_in, amin_ff, amin_in;
   logic [21:0]         fmin_ff, fmin_in, diff_ff, diff_in;
   logic [36:0]         den_ff, den_in, rem_ff, rem_in;
   logic [55:0]         dvd_ff, dvd_in;
   logic [5:0]          dcnt_ff, dcnt_in;
   logic [27:0]         x_ff, x_in;
   logic [31:0]         a_ff, a_in, a2_ff, a2_in;
   logic                esel_ff, esel_in, e1ph_ff, e1ph_in;
   logic [30:0]         r_ff, r_in, t_ff, t_in;
   logic [3:0]          k_ff, k_in;
   logic signed [32:0]  acc_ff, acc_in;
   logic [30:0]         e1_ff, e1_in, v_ff, v_in, ea_ff, ea_in, d_ff, d_in;
   logic [4:0]          pcnt_ff, pcnt_in;
   logic [DISS_W-1:0]   sum_ff, sum_in;
   logic [63:0]         mul_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DISS_W-1:0]   dis_out_ff, dis_out_in;
   logic [RATIO_W-1:0]  int_out_ff, int_out_in;

   logic [31:0]         mul_a, mul_b;
   logic [IDX_W-1:0]    rd_idx, wr_idx;
   logic [FREQ_W-1:0]   rd_freq;
   logic [AMP_W-1:0]    rd_amp;
   logic [CNT_W-1:0]    n_sel;
   logic                req_accept;
   logic [37:0]         div_shift;
   logic                div_ge;
   logic [21:0]         scaled;
   logic [47:0]         a_round;
   logic [48:0]         prod5;
   logic [DISS_W:0]     sum_wide;
   logic [30:0]         ser_clamp;
   logic [31:0]         rcp_m;
   logic [5:0]          rcp_sh;
   logic [30:0]         ser_quot;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dissonance   = dis_out_ff;
   assign rsp_interval_out = int_out_ff;

   assign rd_idx  = (state_ff == ST_ROW_LD) ? i_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];
   assign rd_freq = freq_tbl_ff[rd_idx];
   assign rd_amp  = amp_tbl_ff[rd_idx];
   assign wr_idx  = IDX_W'(req_partial_index);
   assign n_sel   = (32'(piu_ff) > MAX_PARTIALS) ? CNT_W'(MAX_PARTIALS) : CNT_W'(piu_ff);

   assign div_shift = {rem_ff, dvd_ff[55]};
   assign div_ge    = (div_shift >= {1'b0, den_ff});
   assign scaled    = mul_ff[33:12];
   assign a_round   = mul_ff[47:0] + 48'd32768;
   assign prod5     = {2'b00, mul_ff[46:0]} + {mul_ff[46:0], 2'b00};
   assign sum_wide  = {1'b0, sum_ff} + (DISS_W + 1)'(prod5[48:30]);
   assign ser_quot  = 31'(mul_ff >> rcp_sh);

   // series term divide by k: exact floor for dividends below 2^31
   always_comb begin
      unique case (k_ff)
         4'd1:  begin rcp_m = 32'd2147483648; rcp_sh = 6'd31; end
         4'd2:  begin rcp_m = 32'd2147483648; rcp_sh = 6'd32; end
         4'd3:  begin rcp_m = 32'd2863311531; rcp_sh = 6'd33; end
         4'd4:  begin rcp_m = 32'd2147483648; rcp_sh = 6'd33; end
         4'd5:  begin rcp_m = 32'd3435973837; rcp_sh = 6'd34; end
         4'd6:  begin rcp_m = 32'd2863311531; rcp_sh = 6'd34; end
         4'd7:  begin rcp_m = 32'd2454267027; rcp_sh = 6'd34; end
         4'd8:  begin rcp_m = 32'd2147483648; rcp_sh = 6'd34; end
         4'd9:  begin rcp_m = 32'd3817748708; rcp_sh = 6'd35; end
         4'd10: begin rcp_m = 32'd3435973837; rcp_sh = 6'd35; end
         4'd11: begin rcp_m = 32'd3123612579; rcp_sh = 6'd35; end
         4'd12: begin rcp_m = 32'd2863311531; rcp_sh = 6'd35; end
         4'd13: begin rcp_m = 32'd2643056798; rcp_sh = 6'd35; end
         default: begin
            rcp_m  = '0;
            rcp_sh = '0;
         end
      endcase
   end

   always_comb begin
      if (acc_ff < 0) begin
         ser_clamp = '0;
      end else if (acc_ff > $signed({2'b00, Q30_ONE})) begin
         ser_clamp = Q30_ONE;
      end else begin
         ser_clamp = acc_ff[30:0];
      end
   end

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_SC_MUL: begin
            mul_a = 32'(fj_ff);
            mul_b = 32'(ratio_ff);
         end
         ST_DEN_MUL: begin
            mul_a = 32'(fmin_ff);
            mul_b = SLOPE_Q20;
         end
         ST_NUM_MUL: begin
            mul_a = 32'(diff_ff);
            mul_b = DSTAR_Q20;
         end
         ST_A1_MUL: begin
            mul_a = 32'(x_ff);
            mul_b = RATE1_Q16;
         end
         ST_A2_MUL: begin
            mul_a = 32'(x_ff);
            mul_b = RATE2_Q16;
         end
         ST_SER_MUL: begin
            mul_a = 32'(t_ff);
            mul_b = 32'(r_ff);
         end
         ST_SER_RCP: begin
            mul_a = 32'(mul_ff[60:30]);
            mul_b = rcp_m;
         end
         ST_POW: begin
            mul_a = 32'(v_ff);
            mul_b = 32'(e1_ff);
         end
         ST_TERM_MUL: begin
            mul_a = 32'(d_ff);
            mul_b = 32'(amin_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      piu_in       = piu_ff;
      freq_tbl_in  = freq_tbl_ff;
      amp_tbl_in   = amp_tbl_ff;
      ratio_in     = ratio_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      fi_in        = fi_ff;
      fj_in        = fj_ff;
      ai_in        = ai_ff;
      aj_in        = aj_ff;
      amin_in      = amin_ff;
      fmin_in      = fmin_ff;
      diff_in      = diff_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      dcnt_in      = dcnt_ff;
      x_in         = x_ff;
      a_in         = a_ff;
      a2_in        = a2_ff;
      esel_in      = esel_ff;
      e1ph_in      = e1ph_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      e1_in        = e1_ff;
      v_in         = v_ff;
      ea_in        = ea_ff;
      d_in         = d_ff;
      pcnt_in      = pcnt_ff;
      sum_in       = sum_ff;
      dis_out_in   = dis_out_ff;
      int_out_in   = int_out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write_enable) begin
         piu_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_operation == OP_LOAD) begin
                  if (32'(req_partial_index) < MAX_PARTIALS) begin
                     freq_tbl_in[wr_idx] = req_partial_freq;
                     amp_tbl_in[wr_idx]  = req_partial_amp;
                  end
               end else begin
                  ratio_in = req_interval_ratio;
                  n_in     = n_sel;
                  i_in     = '0;
                  j_in     = '0;
                  sum_in   = '0;
                  if (n_sel == '0) begin
                     state_in = ST_FIN;
                  end else begin
                     // e^-1 from the series first
                     r_in     = Q30_ONE;
                     t_in     = Q30_ONE;
                     acc_in   = $signed({2'b00, Q30_ONE});
                     k_in     = 4'd1;
                     e1ph_in  = 1'b1;
                     state_in = ST_SER_MUL;
                  end
               end
            end
         end
         ST_SER_MUL: begin
            state_in = ST_SER_RCP;
         end
         ST_SER_RCP: begin
            state_in = ST_SER_ACC;
         end
         ST_DIV: begin
            rem_in  = div_ge ? 37'(div_shift - {1'b0, den_ff}) : div_shift[36:0];
            dvd_in  = {dvd_ff[54:0], div_ge};
            dcnt_in = dcnt_ff - 6'd1;
            if (dcnt_ff == 6'd1) begin
               state_in = ST_X_DONE;
            end
         end
         ST_SER_ACC: begin
            t_in = ser_quot;
            if (k_ff[0]) begin
               acc_in = acc_ff - $signed({2'b00, ser_quot});
            end else begin
               acc_in = acc_ff + $signed({2'b00, ser_quot});
            end
            k_in     = k_ff + 4'd1;
            state_in = (k_ff == SER_TERMS) ? ST_SER_END : ST_SER_MUL;
         end
         ST_SER_END: begin
            if (e1ph_ff) begin
               e1_in    = ser_clamp;
               e1ph_in  = 1'b0;
               state_in = ST_ROW_LD;
            end else begin
               v_in     = ser_clamp;
               state_in = ST_POW;
            end
         end
         ST_POW: begin
            state_in = (pcnt_ff == '0) ? ST_EXP_END : ST_POW_UPD;
         end
         ST_POW_UPD: begin
            v_in     = mul_ff[60:30];
            pcnt_in  = pcnt_ff - 5'd1;
            state_in = ST_POW;
         end
         ST_EXP_START: begin
            if (a_ff[31:16] >= 16'd32) begin
               v_in     = '0;
               state_in = ST_EXP_END;
            end else begin
               r_in     = {1'b0, a_ff[15:0], 14'd0};
               t_in     = Q30_ONE;
               acc_in   = $signed({2'b00, Q30_ONE});
               k_in     = 4'd1;
               pcnt_in  = a_ff[20:16];
               state_in = ST_SER_MUL;
            end
         end
         ST_EXP_END: begin
            if (!esel_ff) begin
               ea_in    = v_ff;
               esel_in  = 1'b1;
               a_in     = a2_ff;
               state_in = ST_EXP_START;
            end else begin
               d_in     = (ea_ff > v_ff) ? (ea_ff - v_ff) : '0;
               state_in = ST_TERM_MUL;
            end
         end
         ST_TERM_MUL: begin
            state_in = ST_TERM_ADD;
         end
         ST_TERM_ADD: begin
            sum_in = (sum_wide > {1'b0, DISS_MAX}) ? DISS_MAX : sum_wide[DISS_W-1:0];
            if (j_ff + 1'b1 == n_ff) begin
               j_in = '0;
               if (i_ff + 1'b1 == n_ff) begin
                  state_in = ST_FIN;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_ROW_LD;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_COL_LD;
            end
         end
         ST_ROW_LD: begin
            fi_in    = rd_freq;
            ai_in    = rd_amp;
            state_in = ST_COL_LD;
         end
         ST_COL_LD: begin
            fj_in    = rd_freq;
            aj_in    = rd_amp;
            state_in = ST_SC_MUL;
         end
         ST_SC_MUL: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            if (scaled < 22'(fi_ff)) begin
               fmin_in = scaled;
               diff_in = 22'(fi_ff) - scaled;
            end else begin
               fmin_in = 22'(fi_ff);
               diff_in = scaled - 22'(fi_ff);
            end
            amin_in  = (ai_ff < aj_ff) ? ai_ff : aj_ff;
            state_in = ST_DEN_MUL;
         end
         ST_DEN_MUL: begin
            state_in = ST_NUM_MUL;
         end
         ST_NUM_MUL: begin
            den_in   = mul_ff[36:0] + OFFSET_Q24;
            state_in = ST_X_LD;
         end
         ST_X_LD: begin
            dvd_in   = {mul_ff[39:0], 16'd0};
            rem_in   = '0;
            dcnt_in  = 6'd56;
            state_in = ST_DIV;
         end
         ST_X_DONE: begin
            x_in     = dvd_ff[27:0];
            state_in = ST_A1_MUL;
         end
         ST_A1_MUL: begin
            state_in = ST_A2_MUL;
         end
         ST_A2_MUL: begin
            a_in     = a_round[47:16];
            state_in = ST_A2_DONE;
         end
         ST_A2_DONE: begin
            a2_in    = a_round[47:16];
            esel_in  = 1'b0;
            state_in = ST_EXP_START;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               dis_out_in   = sum_ff;
               int_out_in   = ratio_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         piu_ff       <= PIU_RESET;
         rsp_valid_ff <= 1'b0;
         e1ph_ff      <= 1'b0;
         esel_ff      <= 1'b0;
         for (int p = 0; p < MAX_PARTIALS; p++) begin
            freq_tbl_ff[p] <= '0;
            amp_tbl_ff[p]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         piu_ff       <= piu_in;
         rsp_valid_ff <= rsp_valid_in;
         e1ph_ff      <= e1ph_in;
         esel_ff      <= esel_in;
         freq_tbl_ff  <= freq_tbl_in;
         amp_tbl_ff   <= amp_tbl_in;
      end
   end

   always_ff @(posedge clock) begin
      ratio_ff   <= ratio_in;
      n_ff       <= n_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      fi_ff      <= fi_in;
      fj_ff      <= fj_in;
      ai_ff      <= ai_in;
      aj_ff      <= aj_in;
      amin_ff    <= amin_in;
      fmin_ff    <= fmin_in;
      diff_ff    <= diff_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      dcnt_ff    <= dcnt_in;
      x_ff       <= x_in;
      a_ff       <= a_in;
      a2_ff      <= a2_in;
      r_ff       <= r_in;
      t_ff       <= t_in;
      k_ff       <= k_in;
      acc_ff     <= acc_in;
      e1_ff      <= e1_in;
      v_ff       <= v_in;
      ea_ff      <= ea_in;
      d_ff       <= d_in;
      pcnt_ff    <= pcnt_in;
      sum_ff     <= sum_in;
      dis_out_ff <= dis_out_in;
      int_out_ff <= int_out_in;
      mul_ff     <= 64'(mul_a) * 64'(mul_b);
   end

endmodule

/* hdl/sde_checker.sv */
`timescale 1ns / 1ps
module sde_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [sde_pkg::DISS_W-1:0]    rsp_dissonance,
   input logic [sde_pkg::RATIO_W-1:0]   rsp_interval_out
);
   import sde_pkg::*;

   // an evaluate keeps the input side stalled next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == OP_EVAL |=> req_stall)
      else $error("req not stalled after evaluate item");

   // a load never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == OP_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("rsp item after load");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_dissonance) && $stable(rsp_interval_out))
      else $error("rsp payload changed while stalled");

endmodule

bind sensory_dissonance_evaluator sde_checker u_sde_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_dissonance   (rsp_dissonance),
   .rsp_interval_out (rsp_interval_out)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import sde_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_operation = OP_LOAD;
   logic [2:0]          req_partial_index = '0;
   logic [FREQ_W-1:0]   req_partial_freq = '0;
   logic [AMP_W-1:0]    req_partial_amp = '0;
   logic [RATIO_W-1:0]  req_interval_ratio = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DISS_W-1:0]   rsp_dissonance;
   logic [RATIO_W-1:0]  rsp_interval_out;
   logic                csr_write_enable = 1'b0;
   logic [CSR_W-1:0]    csr_write_data = '0;

   typedef struct packed {
      logic [DISS_W-1:0]  dissonance;
      logic [RATIO_W-1:0] interval;
   } diss_result_type;

   localparam int NUM_SLOTS = 8;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;

   logic [FREQ_W-1:0] freq_slot [NUM_SLOTS];
   logic [AMP_W-1:0]  amp_slot [NUM_SLOTS];
   logic [CSR_W-1:0]  partials_setting;
   diss_result_type   pending_dissonance [$];

   int errors = 0;
   int loads_sent = 0;
   int evals_sent = 0;
   int results_seen = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;

   sensory_dissonance_evaluator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_partial_index(req_partial_index),
      .req_partial_freq(req_partial_freq), .req_partial_amp(req_partial_amp),
      .req_interval_ratio(req_interval_ratio),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_dissonance(rsp_dissonance), .rsp_interval_out(rsp_interval_out),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // e^-r for r in [0,1], q1.30
   function automatic longint unsigned exp_series(longint unsigned r);
      longint unsigned t;
      longint acc;
      t = ONE_Q30;
      acc = longint'(ONE_Q30);
      for (int k = 1; k <= 13; k++) begin
         t = ((t * r) >> 30) / longint'(k);
         if (k % 2 == 1) acc = acc - longint'(t);
         else acc = acc + longint'(t);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      return longint'(acc);
   endfunction

   function automatic longint unsigned exp_neg_q30(longint unsigned a);
      longint unsigned whole, v, e_one;
      whole = a >> 16;
      if (whole >= 32) return 0;
      v = exp_series((a & 64'hFFFF) << 14);
      e_one = exp_series(ONE_Q30);
      for (longint unsigned i = 0; i < whole; i++) v = (v * e_one) >> 30;
      return v;
   endfunction

   function automatic longint unsigned pair_dissonance(longint unsigned fi,
         longint unsigned fj, longint unsigned amin);
      longint unsigned fmin, diff, den, x, e1, e2, d;
      fmin = (fj < fi) ? fj : fi;
      diff = (fj < fi) ? fi - fj : fj - fi;
      den = fmin * 64'd21706 + 64'd318096015;
      x = ((diff * 64'd251658) << 16) / den;
      e1 = exp_neg_q30((x * 64'd230031 + 64'd32768) >> 16);
      e2 = exp_neg_q30((x * 64'd376832 + 64'd32768) >> 16);
      d = (e1 > e2) ? e1 - e2 : 0;
      return (64'd5 * d * amin) >> 30;
   endfunction

   function automatic logic [DISS_W-1:0] curve_dissonance(logic [RATIO_W-1:0] ratio);
      longint unsigned scaled [NUM_SLOTS];
      longint unsigned acc, amin;
      int n;
      acc = 0;
      n = (partials_setting > NUM_SLOTS) ? NUM_SLOTS : int'(partials_setting);
      for (int j = 0; j < n; j++)
         scaled[j] = (longint'(freq_slot[j]) * longint'(ratio)) >> 12;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            amin = (amp_slot[i] < amp_slot[j]) ? amp_slot[i] : amp_slot[j];
            acc += pair_dissonance(longint'(freq_slot[i]), scaled[j], amin);
            if (acc > 64'd8388607) acc = 64'd8388607;
         end
      end
      return acc[DISS_W-1:0];
   endfunction

   // result checker
   always @(posedge clock) begin
      diss_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.dissonance = rsp_dissonance;
         got.interval = rsp_interval_out;
         results_seen++;
         if (pending_dissonance.size() == 0) begin
            $display("%0t: unexpected result dissonance %0d interval %0d",
                     $time, got.dissonance, got.interval);
            errors++;
         end else begin
            want = pending_dissonance.pop_front();
            if (got.dissonance !== want.dissonance) begin
               $display("%0t: dissonance expected %0d actual %0d", $time,
                        want.dissonance, got.dissonance);
               errors++;
            end
            if (got.interval !== want.interval) begin
               $display("%0t: interval expected %0d actual %0d", $time,
                        want.interval, got.interval);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_item(logic op, logic [2:0] idx, logic [FREQ_W-1:0] f,
         logic [AMP_W-1:0] a, logic [RATIO_W-1:0] r);
      diss_result_type want;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_partial_index <= idx;
      req_partial_freq <= f;
      req_partial_amp <= a;
      req_interval_ratio <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD) begin
         freq_slot[idx] = f;
         amp_slot[idx] = a;
         loads_sent++;
      end else begin
         want.dissonance = curve_dissonance(r);
         want.interval = r;
         pending_dissonance = {pending_dissonance, want};
         evals_sent++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_dissonance.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_partials(logic [CSR_W-1:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      partials_setting = v;
   endtask

   task automatic load_rand(logic wide);
      logic [FREQ_W-1:0] f;
      f = wide ? FREQ_W'($urandom) : FREQ_W'($urandom_range(1600, 80000));
      send_item(OP_LOAD, 3'($urandom), f, AMP_W'($urandom), RATIO_W'($urandom));
   endtask

   task automatic eval_rand();
      logic [RATIO_W-1:0] r;
      r = ($urandom_range(3) == 0) ? RATIO_W'($urandom) :
          RATIO_W'($urandom_range(4096, 8192));
      send_item(OP_EVAL, 3'($urandom), FREQ_W'($urandom), AMP_W'($urandom), r);
   endtask

   task automatic test_reset_state();
      // empty table with eight partials
      send_item(OP_EVAL, 3'd0, '0, '0, 16'd4096);
      drain();
   endtask

   task automatic test_directed();
      set_partials(4'd2);
      send_item(OP_LOAD, 3'd0, 18'h3FFFF, 16'hFFFF, '0);
      send_item(OP_LOAD, 3'd1, 18'd7040, 16'd32768, '0);
      send_item(OP_LOAD, 3'd7, 18'd4400, 16'hFFFF, '0);
      send_item(OP_EVAL, 3'd0, '0, '0, 16'd0);
      send_item(OP_EVAL, 3'd0, '0, '0, 16'hFFFF);
      send_item(OP_EVAL, 3'd0, '0, '0, 16'd4096);
      send_item(OP_LOAD, 3'd0, 18'd4400, 16'hFFFF, '0);
      send_item(OP_LOAD, 3'd1, 18'd8800, 16'd1, '0);
      send_item(OP_EVAL, 3'd7, 18'h3FFFF, 16'hFFFF, 16'd4352);
      send_item(OP_EVAL, 3'd0, '0, '0, 16'd6144);
      send_item(OP_LOAD, 3'd1, 18'd0, 16'd0, '0);
      send_item(OP_EVAL, 3'd0, '0, '0, 16'd5461);
      set_partials(4'd0);
      send_item(OP_EVAL, 3'd0, '0, '0, 16'd4096);
      set_partials(4'd1);
      send_item(OP_EVAL, 3'd0, '0, '0, 16'd8192);
      // more than the table holds counts as all slots
      set_partials(4'd15);
      send_item(OP_EVAL, 3'd0, '0, '0, 16'd4915);
      drain();
   endtask

   task automatic test_random(int count, int s_pct, int r_pct);
      logic [CSR_W-1:0] choice [6] = '{4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3};
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int k = 0; k < count; k++) begin
         if (k % 60 == 0) set_partials(choice[$urandom_range(5)]);
         if ($urandom_range(99) < 10) eval_rand();
         else load_rand($urandom_range(4) == 0);
      end
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_partials(4'd1);
      hold_left = 4000;
      for (int k = 0; k < 6; k++) eval_rand();
      // sender waits for every result before going on
      drain();
      for (int k = 0; k < 4; k++) begin
         load_rand(1'b0);
         eval_rand();
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         freq_slot[i] = '0;
         amp_slot[i] = '0;
      end
      partials_setting = PIU_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed();
      test_random(310, 23, 72);
      test_random(310, 72, 23);
      test_random(310, 0, 0);
      test_backpressure();
      $display("covered %0d loads and %0d evaluates, %0d results checked,",
               loads_sent, evals_sent, results_seen);
      $display("partial counts 0 to 15, mixed stalls and a long result hold-off");
      if (errors == 0 && pending_dissonance.size() == 0) begin
         $display("PASS sensory_dissonance_evaluator");
      end else begin
         $display("FAIL sensory_dissonance_evaluator");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("FAIL sensory_dissonance_evaluator");
      $finish;
   end

endmodule

/* sensory_dissonance_evaluator.f */
hdl/sde_pkg.sv
hdl/sensory_dissonance_evaluator.sv
hdl/sde_checker.sv
verif/tb_top.sv
